@@ src/csttok_pkg.sv @@
// Shared types and constants for the character stream tokenizer.
`default_nettype none
package csttok_pkg;

  localparam int MAX_NAME_DEF = 100;

  // Token kinds.
  localparam logic [3:0] K_IDENT  = 4'd0;
  localparam logic [3:0] K_WHILE  = 4'd1;
  localparam logic [3:0] K_CONST  = 4'd2;
  localparam logic [3:0] K_LPAREN = 4'd3;
  localparam logic [3:0] K_RPAREN = 4'd4;
  localparam logic [3:0] K_LBRACE = 4'd5;
  localparam logic [3:0] K_RBRACE = 4'd6;
  localparam logic [3:0] K_STAR   = 4'd7;
  localparam logic [3:0] K_ASSIGN = 4'd8;
  localparam logic [3:0] K_SEMI   = 4'd9;
  localparam logic [3:0] K_SLASH  = 4'd10;
  localparam logic [3:0] K_EOF    = 4'd11;
  localparam logic [3:0] K_ERROR  = 4'd12;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h27;

  typedef enum logic [8:0] {
    M_START   = 9'b000000001,
    M_SLASH   = 9'b000000010,
    M_COMMENT = 9'b000000100,
    M_CSTAR   = 9'b000001000,
    M_QUOTE   = 9'b000010000,
    M_ZERO    = 9'b000100000,
    M_HEX     = 9'b001000000,
    M_DEC     = 9'b010000000,
    M_IDENT   = 9'b100000000
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] accum;
    logic [6:0]  name_len;
    logic [2:0]  kw_prog;
    logic        kw_miss;
    logic [15:0] line;
  } state_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [6:0]  len;
    logic [15:0] line;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] n;
    token_t     tok0;
    token_t     tok1;
  } scan_res_t;

endpackage
`default_nettype wire

@@ src/csttok_scan.sv @@
// Combinational scanner: next state and up to two tokens for one byte.
`default_nettype none
module csttok_scan import csttok_pkg::*; #(
  parameter int MAX_NAME = MAX_NAME_DEF
) (
  input  state_t      st_i,
  input  logic [7:0]  ch_i,
  input  logic        eoi_i,
  output state_t      st_o,
  output scan_res_t   res_o
);

  localparam logic [6:0] NameSat = 7'(MAX_NAME - 1);

  function automatic logic [7:0] kw_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = "w";
      3'd1:    c = "h";
      3'd2:    c = "i";
      3'd3:    c = "l";
      default: c = "e";
    endcase
    return c;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  state_t      st;
  logic        e0_v, e1_v, run_start, bump;
  logic [3:0]  e0_k, e1_k;
  logic [31:0] e0_val;
  logic [6:0]  e0_len;
  logic [3:0]  hex_d;

  assign hex_d = is_digit(ch_i) ? ch_i[3:0] : 4'(ch_i[3:0] + 4'd9);

  always_comb begin
    st        = st_i;
    e0_v      = 1'b0;
    e0_k      = K_IDENT;
    e0_val    = '0;
    e0_len    = '0;
    e1_v      = 1'b0;
    e1_k      = K_IDENT;
    run_start = 1'b0;
    bump      = 1'b0;

    if (eoi_i) begin
      case (st_i.mode)
        M_SLASH: begin
          e0_v = 1'b1;
          e0_k = K_SLASH;
        end
        M_COMMENT, M_CSTAR, M_QUOTE: begin
          e0_v = 1'b1;
          e0_k = K_ERROR;
        end
        M_ZERO, M_HEX, M_DEC: begin
          e0_v   = 1'b1;
          e0_k   = K_CONST;
          e0_val = st_i.accum;
        end
        M_IDENT: begin
          e0_v = 1'b1;
          if (!st_i.kw_miss && st_i.kw_prog == 3'd5) begin
            e0_k = K_WHILE;
          end else begin
            e0_k   = K_IDENT;
            e0_len = st_i.name_len;
          end
        end
        default: ;
      endcase
      e1_v        = 1'b1;
      e1_k        = K_EOF;
      st.mode     = M_START;
      st.accum    = '0;
      st.name_len = '0;
      st.kw_prog  = '0;
      st.kw_miss  = 1'b0;
    end else begin
      case (st_i.mode)
        M_SLASH: begin
          if (ch_i == "*") begin
            st.mode = M_COMMENT;
          end else begin
            e0_v      = 1'b1;
            e0_k      = K_SLASH;
            run_start = 1'b1;
          end
        end
        M_COMMENT, M_CSTAR: begin
          if (st_i.mode == M_CSTAR && ch_i == "/") begin
            st.mode = M_START;
          end else if (ch_i == "*") begin
            st.mode = M_CSTAR;
          end else begin
            bump    = (ch_i == CH_NL);
            st.mode = M_COMMENT;
          end
        end
        M_QUOTE: begin
          if (ch_i == CH_QUOTE) begin
            e0_v    = 1'b1;
            e0_k    = K_CONST;
            e0_val  = st_i.accum;
            st.mode = M_START;
          end else begin
            st.accum = {st_i.accum[23:0], ch_i};
          end
        end
        M_ZERO: begin
          if (ch_i == "x" || ch_i == "X") begin
            st.accum = '0;
            st.mode  = M_HEX;
          end else if (is_digit(ch_i)) begin
            st.accum = {28'd0, ch_i[3:0]};
            st.mode  = M_DEC;
          end else begin
            e0_v      = 1'b1;
            e0_k      = K_CONST;
            run_start = 1'b1;
          end
        end
        M_HEX: begin
          if (is_hex(ch_i)) begin
            st.accum = {st_i.accum[27:0], hex_d};
          end else begin
            e0_v      = 1'b1;
            e0_k      = K_CONST;
            e0_val    = st_i.accum;
            run_start = 1'b1;
          end
        end
        M_DEC: begin
          if (is_digit(ch_i)) begin
            // Times ten as eight plus two, then add the digit.
            st.accum = {st_i.accum[28:0], 3'b000} + {st_i.accum[30:0], 1'b0}
                       + {28'd0, ch_i[3:0]};
          end else begin
            e0_v      = 1'b1;
            e0_k      = K_CONST;
            e0_val    = st_i.accum;
            run_start = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(ch_i) || is_digit(ch_i)) begin
            if (st_i.name_len < NameSat) begin
              st.name_len = st_i.name_len + 7'd1;
            end
            if (!st_i.kw_miss && st_i.kw_prog < 3'd5 && ch_i == kw_char(st_i.kw_prog)) begin
              st.kw_prog = st_i.kw_prog + 3'd1;
            end else begin
              st.kw_miss = 1'b1;
            end
          end else begin
            e0_v = 1'b1;
            if (!st_i.kw_miss && st_i.kw_prog == 3'd5) begin
              e0_k = K_WHILE;
            end else begin
              e0_k   = K_IDENT;
              e0_len = st_i.name_len;
            end
            run_start = 1'b1;
          end
        end
        default: run_start = 1'b1;
      endcase

      // The byte that ended a token is scanned again from the start state.
      if (run_start) begin
        st.mode = M_START;
        case (ch_i)
          CH_NL:                 bump = 1'b1;
          " ", CH_TAB, CH_CR:    ;
          "(": begin e1_v = 1'b1; e1_k = K_LPAREN; end
          ")": begin e1_v = 1'b1; e1_k = K_RPAREN; end
          "{": begin e1_v = 1'b1; e1_k = K_LBRACE; end
          "}": begin e1_v = 1'b1; e1_k = K_RBRACE; end
          "*": begin e1_v = 1'b1; e1_k = K_STAR;   end
          "=": begin e1_v = 1'b1; e1_k = K_ASSIGN; end
          ";": begin e1_v = 1'b1; e1_k = K_SEMI;   end
          "/": st.mode = M_SLASH;
          CH_QUOTE: begin
            st.accum = '0;
            st.mode  = M_QUOTE;
          end
          "0": begin
            st.accum = '0;
            st.mode  = M_ZERO;
          end
          default: begin
            if (is_alpha(ch_i)) begin
              st.name_len = 7'd1;
              st.kw_prog  = (ch_i == "w") ? 3'd1 : 3'd0;
              st.kw_miss  = (ch_i != "w");
              st.mode     = M_IDENT;
            end else if (is_digit(ch_i)) begin
              st.accum = {28'd0, ch_i[3:0]};
              st.mode  = M_DEC;
            end else begin
              e1_v = 1'b1;
              e1_k = K_ERROR;
            end
          end
        endcase
      end
    end

    if (bump && st_i.line != 16'hFFFF) begin
      st.line = st_i.line + 16'd1;
    end
  end

  assign st_o = st;

  // Tokens carry the line count as it stood before this byte.
  always_comb begin
    token_t t0, t1;
    t0 = '{kind: e0_k, value: e0_val, len: e0_len, line: st_i.line, last: 1'b0};
    t1 = '{kind: e1_k, value: 32'd0, len: 7'd0, line: st_i.line, last: 1'b1};
    res_o.tok1 = t1;
    if (e0_v) begin
      t0.last    = !e1_v;
      res_o.tok0 = t0;
      res_o.n    = e1_v ? 2'd2 : 2'd1;
    end else begin
      res_o.tok0 = t1;
      res_o.n    = e1_v ? 2'd1 : 2'd0;
    end
  end

endmodule
`default_nettype wire

@@ src/csttok_fifo.sv @@
// Two-entry token queue that takes up to two tokens and gives one per cycle while the reader is ready.
`default_nettype none
module csttok_fifo import csttok_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  push_n_i,
  input  token_t      push0_i,
  input  token_t      push1_i,
  output logic [1:0]  avail_o,
  output logic        valid_o,
  input  logic        ready_i,
  output token_t      head_o
);

  token_t     slot0_r, slot1_r, slot0_nxt, slot1_nxt;
  logic [1:0] count_r, count_nxt, rem;
  logic       pop;

  assign valid_o = (count_r != 2'd0);
  assign head_o  = slot0_r;
  assign pop     = valid_o && ready_i;
  assign rem     = count_r - {1'b0, pop};
  // Room left once this cycle's pop is counted.
  assign avail_o = 2'd2 - rem;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    case (rem)
      2'd2: ;
      2'd1: begin
        slot0_nxt = pop ? slot1_r : slot0_r;
        slot1_nxt = push0_i;
      end
      default: begin
        slot0_nxt = push0_i;
        slot1_nxt = push1_i;
      end
    endcase
    count_nxt = rem + push_n_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule
`default_nettype wire

@@ src/char_stream_tokenizer.sv @@
// Top level of the character stream tokenizer.
// The in_ channel takes one source byte per word in in_tdata, with in_tuser
// high to mark the end of the source text (the byte is then ignored).
// The out_ channel gives tokens: kind, constant value, identifier length and
// line number in out_tdata; out_tlast marks the final token of an input word.
// A word is held in an input register, scanned combinationally against the
// scanner state, and its zero, one or two tokens go to a two-entry queue.
// Tokens pass through the input register and then the queue to the out_
// channel. One byte is taken every cycle while the out_ side keeps up; a
// byte that gives two tokens can hold the input back, as the queue hands
// out one token per cycle. A stall on out_ fills the queue, then holds the
// word in the input register, then drops in_tready; nothing is lost.
// Reset empties the queue and input register, puts the scanner in its start
// state and sets the line count to one.
`default_nettype none
module char_stream_tokenizer import csttok_pkg::*; #(
  parameter int MAX_NAME = MAX_NAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [3:0] token_kind, [35:4] token_value,
                                  // [42:36] ident_length, [58:43] line_number
  output logic        out_tlast
);

  logic       in_valid_r;
  logic [7:0] in_ch_r;
  logic       in_eoi_r;
  state_t     st_r, st_scan;
  scan_res_t  res;
  logic [1:0] avail;
  logic       fire;
  token_t     head;

  csttok_scan #(.MAX_NAME(MAX_NAME)) u_scan (
    .st_i  (st_r),
    .ch_i  (in_ch_r),
    .eoi_i (in_eoi_r),
    .st_o  (st_scan),
    .res_o (res)
  );

  assign fire      = in_valid_r && (res.n <= avail);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      st_r       <= '{mode: M_START, accum: 32'd0, name_len: 7'd0, kw_prog: 3'd0,
                      kw_miss: 1'b0, line: 16'd1};
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (fire) begin
        st_r <= st_scan;
      end
    end
    if (in_tvalid && in_tready) begin
      in_ch_r  <= in_tdata;
      in_eoi_r <= in_tuser;
    end
  end

  csttok_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n_i (fire ? res.n : 2'd0),
    .push0_i  (res.tok0),
    .push1_i  (res.tok1),
    .avail_o  (avail),
    .valid_o  (out_tvalid),
    .ready_i  (out_tready),
    .head_o   (head)
  );

  assign out_tdata = {5'd0, head.line, head.len, head.value, head.kind};
  assign out_tlast = head.last;

endmodule
`default_nettype wire
